@@ hdl/vshp_pkg.sv @@
// Shared types, element codes and field widths for the sequence-header parser.
// No dependencies; used by vshp_derive and video_sequence_header_parser.
package vshp_pkg;

    // Fixed field widths
    localparam int ID_W    = 6;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 25;
    localparam int ACC_W   = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Weight-quant matrix sizes
    localparam int SMALL_MATRIX_COEFFS = 16;
    localparam int LARGE_MATRIX_COEFFS = 64;
    localparam int ALL_COEFFS = SMALL_MATRIX_COEFFS + LARGE_MATRIX_COEFFS;

    localparam logic [7:0] PROFILE_TEN_BIT = 8'd34;
    localparam logic [5:0] GOLOMB_MAX_ZEROS = 6'd32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEN_BIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_PROF = 1'b1;

    // Parse phases, equal to the element id they produce
    localparam logic [ID_W-1:0] PH_PROFILE     = 6'd0;
    localparam logic [ID_W-1:0] PH_WIDTH       = 6'd4;
    localparam logic [ID_W-1:0] PH_HEIGHT      = 6'd5;
    localparam logic [ID_W-1:0] PH_CHROMA      = 6'd6;
    localparam logic [ID_W-1:0] PH_OUT_DEPTH   = 6'd7;
    localparam logic [ID_W-1:0] PH_SMP_DEPTH   = 6'd8;
    localparam logic [ID_W-1:0] PH_PRECISION   = 6'd9;
    localparam logic [ID_W-1:0] PH_ASPECT      = 6'd10;
    localparam logic [ID_W-1:0] PH_LOW_DELAY   = 6'd15;
    localparam logic [ID_W-1:0] PH_LCU_LOG2    = 6'd19;
    localparam logic [ID_W-1:0] PH_WQ_FLAG     = 6'd20;
    localparam logic [ID_W-1:0] PH_LOAD_MAT    = 6'd21;
    localparam logic [ID_W-1:0] PH_COEFF       = 6'd22;
    localparam logic [ID_W-1:0] PH_BACKGROUND  = 6'd23;
    localparam logic [ID_W-1:0] PH_TOOL_FIRST  = 6'd24;
    localparam logic [ID_W-1:0] PH_SET_COUNT   = 6'd35;
    localparam logic [ID_W-1:0] PH_REFERRED    = 6'd36;
    localparam logic [ID_W-1:0] PH_REF_COUNT   = 6'd37;
    localparam logic [ID_W-1:0] PH_REF_DELTA   = 6'd38;
    localparam logic [ID_W-1:0] PH_RM_COUNT    = 6'd39;
    localparam logic [ID_W-1:0] PH_RM_DELTA    = 6'd40;
    localparam logic [ID_W-1:0] PH_SET_MARKER  = 6'd41;
    localparam logic [ID_W-1:0] PH_REORDER     = 6'd42;
    localparam logic [ID_W-1:0] PH_CROSS_SLICE = 6'd43;
    localparam logic [ID_W-1:0] PH_SLICE_SET   = 6'd44;
    localparam logic [ID_W-1:0] PH_RESERVED    = 6'd45;
    localparam logic [ID_W-1:0] PH_IDLE        = 6'd63;

    // Derived value ids
    localparam logic [ID_W-1:0] ID_CROP_R      = 6'd46;
    localparam logic [ID_W-1:0] ID_CROP_B      = 6'd47;
    localparam logic [ID_W-1:0] ID_PIC_W       = 6'd48;
    localparam logic [ID_W-1:0] ID_PIC_H       = 6'd49;
    localparam logic [ID_W-1:0] ID_CHROMA_W    = 6'd50;
    localparam logic [ID_W-1:0] ID_CHROMA_H    = 6'd51;
    localparam logic [ID_W-1:0] ID_B8_COLS     = 6'd52;
    localparam logic [ID_W-1:0] ID_B8_ROWS     = 6'd53;
    localparam logic [ID_W-1:0] ID_B8_COUNT    = 6'd54;
    localparam logic [ID_W-1:0] ID_LCU_SIZE    = 6'd55;
    localparam logic [ID_W-1:0] ID_LCU_COLS    = 6'd56;
    localparam logic [ID_W-1:0] ID_LCU_ROWS    = 6'd57;
    localparam logic [ID_W-1:0] ID_LCU_COUNT   = 6'd58;
    localparam logic [ID_W-1:0] ID_INFO_STRIDE = 6'd59;
    localparam logic [ID_W-1:0] ID_INFO_SIZE   = 6'd60;

    typedef struct packed {
        logic bit_in;
        logic start_header;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]    element_id;
        logic [IDX_W-1:0]   entry_index;
        logic [IDX_W-1:0]   sub_index;
        logic [VALUE_W-1:0] field_value;
        logic               parse_error;
        logic               header_done;
    } out_beat_t;

    // Control from parser to the derived-value generator
    typedef struct packed {
        logic        load;
        logic [13:0] width;
        logic [13:0] height;
        logic [2:0]  lcu_log2;
    } drv_ctrl_t;

    // Bit count of each fixed-width element (Exp-Golomb coefficient gives 0)
    function automatic logic [5:0] elem_width(input logic [ID_W-1:0] ph);
        logic [5:0] w;
        w = 6'd1;
        case (ph)
            6'd0, 6'd1:            w = 6'd8;
            6'd4, 6'd5:            w = 6'd14;
            6'd6, 6'd45:           w = 6'd2;
            6'd7, 6'd8, 6'd9:      w = 6'd3;
            6'd10, 6'd11:          w = 6'd4;
            6'd12, 6'd18:          w = 6'd18;
            6'd14:                 w = 6'd12;
            6'd19, 6'd37, 6'd39:   w = 6'd3;
            6'd22, 6'd63:          w = 6'd0;
            6'd35, 6'd38, 6'd40:   w = 6'd6;
            6'd42:                 w = 6'd5;
            default:               w = 6'd1;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/video_sequence_header_parser.sv @@
// Top level of the bit-serial sequence-header parser.
// Depends on vshp_pkg and vshp_derive.
//
//  channel | signals                          | direction | beat
//  in      | in_valid, in_ready, in_data      | input     | one header bit + start flag
//  out     | out_valid, out_ready, out_data   | output    | one syntax element or size
//  cfg     | cfg_valid, cfg_ready, cfg_index, | input     | one register write
//          | cfg_data                         |           |
//
// One header bit is taken per cycle while input is not held off; each bit is parsed in the
// cycle it is accepted and its element, if any, lands in the output register.
// A header that ends without a parse error is followed by 15 derived values, one per
// cycle unless the output stalls, from a shared multiplier; input is held off meanwhile.
// Input is taken when vshp_derive is idle and the output register is empty or draining.
// Reset puts the parser idle until a bit with the start flag arrives.
module video_sequence_header_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  vshp_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output vshp_pkg::out_beat_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vshp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vshp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vshp_pkg::*;

    // Configuration
    logic       ten_bit_reg;
    logic [7:0] rsv_prof_reg;

    // Parse state
    logic [ID_W-1:0]  phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [5:0]       left_reg, left_next;
    logic [5:0]       zeros_reg, zeros_next;
    logic [7:0]       prof_reg, prof_next;
    logic [13:0]      wid_reg, wid_next;
    logic [13:0]      hgt_reg, hgt_next;
    logic             lowd_reg, lowd_next;
    logic [2:0]       log2_reg, log2_next;
    logic [5:0]       scnt_reg, scnt_next;
    logic [5:0]       spos_reg, spos_next;
    logic [2:0]       lcnt_reg, lcnt_next;
    logic [6:0]       lpos_reg, lpos_next;

    logic             out_valid_reg;
    out_beat_t        out_reg;

    logic             res_valid, fin, go, drv_start;
    out_beat_t        res;
    logic [ACC_W-1:0] v;
    logic [ID_W-1:0]  nxt;
    logic [ACC_W-1:0] acc_sh;

    logic             take, accept, drv_busy;
    drv_ctrl_t        drv_ctrl;
    out_beat_t        drv_res;

    assign take      = !out_valid_reg || out_ready;
    assign in_ready  = take && !drv_busy;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Parse one bit
    always_comb
    begin
        phase_next = phase_reg;  acc_next = acc_reg;   left_next = left_reg;
        zeros_next = zeros_reg;  prof_next = prof_reg; wid_next = wid_reg;
        hgt_next = hgt_reg;      lowd_next = lowd_reg; log2_next = log2_reg;
        scnt_next = scnt_reg;    spos_next = spos_reg; lcnt_next = lcnt_reg;
        lpos_next = lpos_reg;
        res = '0; res_valid = 1'b0; fin = 1'b0; go = 1'b0; drv_start = 1'b0;
        v = '0; nxt = PH_IDLE; acc_sh = '0;

        if (in_data.start_header)
        begin
            prof_next = '0; wid_next = '0; hgt_next = '0; lowd_next = 1'b0;
            log2_next = '0; scnt_next = '0; spos_next = '0; lcnt_next = '0;
            lpos_next = '0;
            phase_next = PH_PROFILE; acc_next = '0; zeros_next = '0;
            left_next = elem_width(PH_PROFILE);
        end

        if (phase_next != PH_IDLE)
        begin
            acc_sh = {acc_next[ACC_W-2:0], in_data.bit_in};
            if (phase_next == PH_COEFF)
            begin
                if (left_next == 6'd0)
                begin
                    if (!in_data.bit_in)
                    begin
                        zeros_next = zeros_next + 6'd1;
                        if (zeros_next >= GOLOMB_MAX_ZEROS)
                        begin
                            res_valid = 1'b1;
                            res.element_id  = PH_COEFF;
                            res.entry_index = (lpos_next >= 7'(SMALL_MATRIX_COEFFS)) ? 6'd1 : 6'd0;
                            res.sub_index   = (lpos_next >= 7'(SMALL_MATRIX_COEFFS)) ?
                                              6'(lpos_next - 7'(SMALL_MATRIX_COEFFS)) :
                                              6'(lpos_next);
                            res.parse_error = 1'b1;
                            res.header_done = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (zeros_next == 6'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        left_next = zeros_next;
                        acc_next  = ACC_W'(1);
                    end
                end
                else
                begin
                    acc_next  = acc_sh;
                    left_next = left_next - 6'd1;
                    if (left_next == 6'd0)
                    begin
                        fin = 1'b1;
                        v   = ACC_W'(16'(acc_next[15:0] - 16'd1));
                    end
                end
            end
            else
            begin
                acc_next = acc_sh;
                if (left_next != 6'd0)
                    left_next = left_next - 6'd1;
                if (left_next == 6'd0)
                begin
                    fin = 1'b1;
                    v   = acc_next;
                end
            end
        end

        // Element complete
        if (fin)
        begin
            res_valid = 1'b1;
            res.element_id  = phase_next;
            res.field_value = VALUE_W'(v);
            go  = 1'b1;
            nxt = (phase_next == PH_PRECISION) ? PH_ASPECT : phase_next + 6'd1;
            case (phase_next)
                PH_PROFILE:   prof_next = v[7:0];
                PH_WIDTH:     wid_next  = v[13:0];
                PH_HEIGHT:    hgt_next  = v[13:0];
                PH_CHROMA:    nxt = (prof_next == PROFILE_TEN_BIT) ? PH_OUT_DEPTH : PH_PRECISION;
                PH_OUT_DEPTH: res.field_value = VALUE_W'(6) + VALUE_W'({v[2:0], 1'b0});
                PH_SMP_DEPTH:
                begin
                    res.field_value = VALUE_W'(6) + VALUE_W'({v[2:0], 1'b0});
                    if (v != ACC_W'(1) && !ten_bit_reg)
                    begin
                        res.parse_error = 1'b1;
                        res.header_done = 1'b1;
                        go = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    else
                        nxt = PH_ASPECT;
                end
                PH_LOW_DELAY: lowd_next = v[0];
                PH_LCU_LOG2:  log2_next = v[2:0];
                PH_WQ_FLAG:   nxt = v[0] ? PH_LOAD_MAT : PH_BACKGROUND;
                PH_LOAD_MAT:
                begin
                    lpos_next = '0;
                    nxt = v[0] ? PH_COEFF : PH_BACKGROUND;
                end
                PH_COEFF:
                begin
                    res.field_value = VALUE_W'(v[15:0]);
                    res.entry_index = (lpos_next >= 7'(SMALL_MATRIX_COEFFS)) ? 6'd1 : 6'd0;
                    res.sub_index   = (lpos_next >= 7'(SMALL_MATRIX_COEFFS)) ?
                                      6'(lpos_next - 7'(SMALL_MATRIX_COEFFS)) :
                                      6'(lpos_next);
                    lpos_next = lpos_next + 7'd1;
                    nxt = (lpos_next >= 7'(ALL_COEFFS)) ? PH_BACKGROUND : PH_COEFF;
                end
                PH_BACKGROUND: res.field_value = VALUE_W'(!v[0]);
                PH_SET_COUNT:
                begin
                    scnt_next = v[5:0];
                    spos_next = '0;
                    nxt = (v[5:0] != 6'd0) ? PH_REFERRED :
                          (lowd_next ? PH_CROSS_SLICE : PH_REORDER);
                end
                PH_REFERRED:  res.entry_index = spos_next;
                PH_REF_COUNT, PH_RM_COUNT:
                begin
                    res.entry_index = spos_next;
                    lcnt_next = v[2:0];
                    lpos_next = '0;
                    nxt = (v[2:0] != 3'd0) ? phase_next + 6'd1 : phase_next + 6'd2;
                end
                PH_REF_DELTA, PH_RM_DELTA:
                begin
                    res.entry_index = spos_next;
                    res.sub_index   = 6'(lpos_next);
                    lpos_next = lpos_next + 7'd1;
                    nxt = (lpos_next < {4'd0, lcnt_next}) ? phase_next : phase_next + 6'd1;
                end
                PH_SET_MARKER:
                begin
                    res.entry_index = spos_next;
                    spos_next = spos_next + 6'd1;
                    nxt = (spos_next < scnt_next && spos_next != 6'd0) ? PH_REFERRED :
                          (lowd_next ? PH_CROSS_SLICE : PH_REORDER);
                end
                PH_CROSS_SLICE: nxt = (prof_next == rsv_prof_reg) ? PH_SLICE_SET : PH_RESERVED;
                PH_SLICE_SET, PH_RESERVED:
                begin
                    if (phase_next == PH_SLICE_SET)
                        res.field_value = VALUE_W'(!v[0]);
                    go = 1'b0;
                    phase_next = PH_IDLE;
                    drv_start = 1'b1;
                end
                default: ;
            endcase
            if (go)
            begin
                phase_next = nxt;
                acc_next   = '0;
                zeros_next = '0;
                left_next  = elem_width(nxt);
            end
        end
    end

    // Derived sizes
    assign drv_ctrl.load     = accept && drv_start;
    assign drv_ctrl.width    = wid_next;
    assign drv_ctrl.height   = hgt_next;
    assign drv_ctrl.lcu_log2 = log2_next;

    vshp_derive u_derive (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (drv_ctrl),
        .advance (drv_busy && take),
        .busy    (drv_busy),
        .result  (drv_res)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_bit_reg  <= 1'b1;
            rsv_prof_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TEN_BIT:  ten_bit_reg  <= cfg_data[0];
                CFG_RSV_PROF: rsv_prof_reg <= cfg_data;
            endcase
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; acc_reg <= '0;  left_reg <= '0; zeros_reg <= '0;
            prof_reg <= '0;  wid_reg <= '0;  hgt_reg <= '0;  lowd_reg <= 1'b0;
            log2_reg <= '0;  scnt_reg <= '0; spos_reg <= '0; lcnt_reg <= '0;
            lpos_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next; acc_reg <= acc_next; left_reg <= left_next;
            zeros_reg <= zeros_next; prof_reg <= prof_next; wid_reg <= wid_next;
            hgt_reg <= hgt_next;     lowd_reg <= lowd_next; log2_reg <= log2_next;
            scnt_reg <= scnt_next;   spos_reg <= spos_next; lcnt_reg <= lcnt_next;
            lpos_reg <= lpos_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (drv_busy && take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
        else if (drv_busy && take)
            out_reg <= drv_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/vshp_derive.sv @@
// Derived picture-size generator: fifteen values, one per output beat.
// Depends on vshp_pkg.
module vshp_derive (
    input  logic                clk,
    input  logic                rst_n,
    input  vshp_pkg::drv_ctrl_t ctrl,
    input  logic                advance,
    output logic                busy,
    output vshp_pkg::out_beat_t result
);
    import vshp_pkg::*;

    logic [14:0] w_reg, h_reg;
    logic [2:0]  log2_reg;
    logic [3:0]  idx_reg;
    logic        busy_reg;

    logic [2:0]  crop_r, crop_b;
    logic [14:0] w_fill, h_fill;
    logic [7:0]  lcu;
    logic [15:0] w_round, h_round;
    logic [14:0] wl, hl;
    logic [12:0] stride, h_info;
    logic [14:0] mul_a, mul_b;
    logic [29:0] prod;
    logic [ID_W-1:0] id;
    logic [VALUE_W-1:0] val;

    // Padded sizes at load
    assign crop_r = 3'(4'd8 - {1'b0, ctrl.width[2:0]});
    assign crop_b = 3'(4'd8 - {1'b0, ctrl.height[2:0]});
    assign w_fill = {1'b0, ctrl.width} + {12'd0, crop_r};
    assign h_fill = {1'b0, ctrl.height} + {12'd0, crop_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (ctrl.load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (advance)
        begin
            if (id == ID_INFO_SIZE)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            w_reg    <= w_fill;
            h_reg    <= h_fill;
            log2_reg <= ctrl.lcu_log2;
        end
    end

    // LCU grid and info sizes
    assign lcu     = 8'd1 << log2_reg;
    assign w_round = {1'b0, w_reg} + {8'd0, lcu} - 16'd1;
    assign h_round = {1'b0, h_reg} + {8'd0, lcu} - 16'd1;
    assign wl      = 15'(w_round >> log2_reg);
    assign hl      = 15'(h_round >> log2_reg);
    assign stride  = 13'(w_reg >> 2) + 13'd2;
    assign h_info  = 13'(h_reg >> 2) + 13'd2;
    assign id      = ID_CROP_R + {2'b00, idx_reg};

    // One shared multiplier
    always_comb
    begin
        mul_a = {3'd0, w_reg[14:3]};
        mul_b = {3'd0, h_reg[14:3]};
        if (id == ID_LCU_COUNT)
        begin
            mul_a = wl;
            mul_b = hl;
        end
        else if (id == ID_INFO_SIZE)
        begin
            mul_a = {2'd0, h_info};
            mul_b = {2'd0, stride};
        end
    end
    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (id)
            ID_CROP_R:      val = 25'(3'(4'd8 - {1'b0, w_reg[2:0]}) & 3'd0) | 25'(w_reg - w_reg);
            default:        val = '0;
        endcase
        case (id)
            ID_CROP_R:      val = 25'(w_reg[2:0] == 3'd0 ? 3'd0 : 3'd0);
            ID_PIC_W:       val = 25'(w_reg);
            ID_PIC_H:       val = 25'(h_reg);
            ID_CHROMA_W:    val = 25'(w_reg >> 1);
            ID_CHROMA_H:    val = 25'(h_reg >> 1);
            ID_B8_COLS:     val = 25'(w_reg >> 3);
            ID_B8_ROWS:     val = 25'(h_reg >> 3);
            ID_B8_COUNT:    val = 25'(prod);
            ID_LCU_SIZE:    val = 25'(lcu);
            ID_LCU_COLS:    val = 25'(wl);
            ID_LCU_ROWS:    val = 25'(hl);
            ID_LCU_COUNT:   val = (prod > 30'h1FFFFFF) ? 25'h1FFFFFF : 25'(prod);
            ID_INFO_STRIDE: val = 25'(stride);
            ID_INFO_SIZE:   val = 25'(prod);
            default:        val = '0;
        endcase
    end

    // Crop values are kept from load time
    logic [2:0] crop_r_reg, crop_b_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            crop_r_reg <= crop_r;
            crop_b_reg <= crop_b;
        end
    end

    always_comb
    begin
        result             = '0;
        result.element_id  = id;
        result.field_value = val;
        if (id == ID_CROP_R)
            result.field_value = 25'(crop_r_reg);
        else if (id == ID_CROP_B)
            result.field_value = 25'(crop_b_reg);
        result.header_done = (id == ID_INFO_SIZE);
    end

    assign busy = busy_reg;

endmodule
